### rtl/assert_macros.svh
// assertion helpers used by the engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SRMQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication outside reset
`define SRMQ_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

`endif

### rtl/srmq_pkg.sv
`default_nettype none

package srmq_pkg;

  // table geometry
  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned POS_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = POS_W + 1;
  localparam int unsigned LEVELS      = POS_W + 1;
  localparam int unsigned LVL_W       = $clog2(LEVELS);
  localparam int unsigned ADDR_W      = LVL_W + POS_W;
  localparam int unsigned MEM_DEPTH   = LEVELS * DEPTH;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_LOAD_LVL,
    ST_QUERY0,
    ST_QUERY1,
    ST_QUERY2
  } state_e;

  typedef struct packed {
    logic                   kind;
    logic [VALUE_WIDTH-1:0] value;
    logic [POS_W-1:0]       left;
    logic [POS_W-1:0]       right;
  } item_t;

  typedef struct packed {
    logic                   valid;
    logic [VALUE_WIDTH-1:0] minimum;
    logic                   error;
  } res_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

  // signed minimum of two values
  function automatic logic [VALUE_WIDTH-1:0] smin(input logic [VALUE_WIDTH-1:0] a,
                                                  input logic [VALUE_WIDTH-1:0] b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

  // position of the highest set bit, zero for zero
  function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (x[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/srmq_ram.sv
`default_nettype none

module srmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port; read data holds without re
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/srmq_engine.sv
`default_nettype none
`include "assert_macros.svh"

module srmq_engine (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire srmq_pkg::item_t                    item_i,
  output logic                                    ready_o,
  input  wire logic                               slot_free_i,
  output srmq_pkg::res_t                          res_o,
  output srmq_pkg::mem_req_t                      mem_o,
  input  wire logic [srmq_pkg::VALUE_WIDTH-1:0]   rdata_i
);

  srmq_pkg::state_e                     state_q, state_d;
  srmq_pkg::item_t                      item_q, item_d;
  logic [srmq_pkg::CNT_W-1:0]           count_q, count_d;
  logic [srmq_pkg::LVL_W-1:0]           lvl_q, lvl_d;
  logic [srmq_pkg::VALUE_WIDTH-1:0]     cur_q, cur_d;
  logic [srmq_pkg::VALUE_WIDTH-1:0]     a_q, a_d;
  logic [srmq_pkg::POS_W-1:0]           k_q, k_d;

  // load addressing: spans ending at the new position
  logic [srmq_pkg::CNT_W:0]             pp1;
  logic [srmq_pkg::CNT_W:0]             span_cur;
  logic [srmq_pkg::CNT_W:0]             span_nxt;
  logic [srmq_pkg::POS_W-1:0]           idx_cur;
  logic [srmq_pkg::POS_W-1:0]           idx_nxt;
  logic                                 more;
  logic [srmq_pkg::VALUE_WIDTH-1:0]     min_v;

  // query decode
  logic                                 q_err;
  logic [srmq_pkg::CNT_W-1:0]           q_len;
  logic [srmq_pkg::LVL_W-1:0]           q_lvl;
  logic [srmq_pkg::CNT_W-1:0]           q_span;
  logic [srmq_pkg::POS_W-1:0]           q_k;
  logic                                 full;

  assign full     = (count_q == srmq_pkg::CNT_W'(srmq_pkg::DEPTH));
  assign pp1      = (srmq_pkg::CNT_W + 1)'(count_q) + 1'b1;
  assign span_cur = (srmq_pkg::CNT_W + 1)'(1) << lvl_q;
  assign span_nxt = span_cur << 1;
  assign idx_cur  = srmq_pkg::POS_W'(pp1 - span_cur);
  assign idx_nxt  = srmq_pkg::POS_W'(pp1 - span_nxt);
  assign more     = (lvl_q != srmq_pkg::LVL_W'(srmq_pkg::LEVELS - 1)) && (span_nxt <= pp1);
  assign min_v    = srmq_pkg::smin(rdata_i, cur_q);

  assign q_err  = (item_q.left > item_q.right) ||
                  (srmq_pkg::CNT_W'(item_q.right) >= count_q);
  assign q_len  = srmq_pkg::CNT_W'(item_q.right) - srmq_pkg::CNT_W'(item_q.left) + 1'b1;
  assign q_lvl  = srmq_pkg::floor_log2(q_len);
  assign q_span = srmq_pkg::CNT_W'(1) << q_lvl;
  assign q_k    = srmq_pkg::POS_W'(srmq_pkg::CNT_W'(item_q.right) + 1'b1 - q_span);

  assign ready_o = (state_q == srmq_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srmq_pkg::ST_IDLE: begin
        if (start_i) begin
          if (item_i.kind == srmq_pkg::KIND_QUERY) begin
            state_d = srmq_pkg::ST_QUERY0;
          end else if (!full) begin
            state_d = srmq_pkg::ST_LOAD0;
          end
        end
      end
      srmq_pkg::ST_LOAD0, srmq_pkg::ST_LOAD_LVL: begin
        state_d = more ? srmq_pkg::ST_LOAD_LVL : srmq_pkg::ST_IDLE;
      end
      srmq_pkg::ST_QUERY0: begin
        if (!q_err) begin
          state_d = srmq_pkg::ST_QUERY1;
        end else if (slot_free_i) begin
          state_d = srmq_pkg::ST_IDLE;
        end
      end
      srmq_pkg::ST_QUERY1: begin
        state_d = srmq_pkg::ST_QUERY2;
      end
      srmq_pkg::ST_QUERY2: begin
        if (slot_free_i) begin
          state_d = srmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srmq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory requests
  always_comb begin
    item_d  = item_q;
    count_d = count_q;
    lvl_d   = lvl_q;
    cur_d   = cur_q;
    a_d     = a_q;
    k_d     = k_q;
    mem_o   = '0;
    res_o   = '0;
    case (state_q)
      srmq_pkg::ST_IDLE: begin
        if (start_i) begin
          item_d = item_i;
          lvl_d  = '0;
        end
      end
      // level zero takes the value itself
      srmq_pkg::ST_LOAD0: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = {srmq_pkg::LVL_W'(0), count_q[srmq_pkg::POS_W-1:0]};
        mem_o.wdata = item_q.value;
        cur_d       = item_q.value;
        if (more) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = {lvl_q, idx_nxt};
          lvl_d       = lvl_q + 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      // merge older half span with the running minimum
      srmq_pkg::ST_LOAD_LVL: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = {lvl_q, idx_cur};
        mem_o.wdata = min_v;
        cur_d       = min_v;
        if (more) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = {lvl_q, idx_nxt};
          lvl_d       = lvl_q + 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      srmq_pkg::ST_QUERY0: begin
        if (q_err) begin
          res_o.valid   = slot_free_i;
          res_o.minimum = '0;
          res_o.error   = 1'b1;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = {q_lvl, item_q.left};
          lvl_d       = q_lvl;
          k_d         = q_k;
        end
      end
      srmq_pkg::ST_QUERY1: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = {lvl_q, k_q};
        a_d         = rdata_i;
      end
      srmq_pkg::ST_QUERY2: begin
        res_o.valid   = slot_free_i;
        res_o.minimum = srmq_pkg::smin(a_q, rdata_i);
        res_o.error   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srmq_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    lvl_q  <= lvl_d;
    cur_q  <= cur_d;
    a_q    <= a_d;
    k_q    <= k_d;
  end

  `SRMQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= srmq_pkg::CNT_W'(srmq_pkg::DEPTH), "loaded count past depth")
  `SRMQ_ASSERT_IMPL(a_no_rw_clash, clk_i, rst_ni, mem_o.we && mem_o.re, mem_o.waddr != mem_o.raddr, "read and write hit one entry")
  `SRMQ_ASSERT_IMPL(a_lvl_range, clk_i, rst_ni, state_q == srmq_pkg::ST_LOAD_LVL, (lvl_q != '0) && (lvl_q < srmq_pkg::LVL_W'(srmq_pkg::LEVELS)), "load level out of range")
  `SRMQ_ASSERT_IMPL(a_load_done, clk_i, rst_ni, $past(state_q) == srmq_pkg::ST_LOAD_LVL && state_q == srmq_pkg::ST_IDLE, count_q == $past(count_q) + 1'b1, "load finished without count step")

endmodule

`default_nettype wire

### rtl/sparse_table_range_minimum.sv
`default_nettype none
// channel   dir  tdata                                tuser
// s_*       in   value[31:0] left[41:32] right[51:42] kind (0 load, 1 query)
// m_*       out  minimum[31:0]                        error
//
// a load writes one table entry per level, level zero first, each higher level
// merging an older half span read through the single read port of the table memory
// a query makes two table reads; a bad range makes none and gives an error word
// a load into a full table is dropped and gives no word
// reset clears loaded count, state and output valid; entries are written before read
// a stalled output word holds; the next item is taken while it waits

module sparse_table_range_minimum (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [55:0] s_tdata_i,  // value[31:0], left[41:32], right[51:42], zero pad
  input  wire logic        s_tuser_i,  // kind
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [31:0] m_tdata_o,  // minimum[31:0]
  output logic             m_tuser_o   // error
);

  srmq_pkg::item_t                   item;
  srmq_pkg::res_t                    res;
  srmq_pkg::mem_req_t                mem_req;
  logic [srmq_pkg::VALUE_WIDTH-1:0]  rdata;
  logic                              ready;
  logic                              start;
  logic                              slot_free;
  logic                              m_valid_q, m_valid_d;
  logic [31:0]                       m_data_q, m_data_d;
  logic                              m_err_q, m_err_d;

  // unpack the input word
  assign item.kind  = s_tuser_i;
  assign item.value = s_tdata_i[31:0];
  assign item.left  = s_tdata_i[41:32];
  assign item.right = s_tdata_i[51:42];

  assign s_tready_o = ready;
  assign start      = s_tvalid_i && ready;
  assign slot_free  = !m_valid_q || m_tready_i;

  srmq_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .ready_o     (ready),
    .slot_free_i (slot_free),
    .res_o       (res),
    .mem_o       (mem_req),
    .rdata_i     (rdata)
  );

  srmq_ram #(
    .WIDTH (srmq_pkg::VALUE_WIDTH),
    .DEPTH (srmq_pkg::MEM_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // output word register
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_err_d   = m_err_q;
    if (res.valid) begin
      m_valid_d = 1'b1;
      m_data_d  = res.minimum;
      m_err_d   = res.error;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_err_q  <= m_err_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_err_q;

endmodule

`default_nettype wire
